@@ rtl/core/bs2w_pkg.sv @@
// Package for the 2D blend-space weight block: payload structs, FSM and
// register codes, divider handshake types. No dependencies.
`default_nettype none
package bs2w_pkg;

  localparam int CW = 16;  // coordinate width, Q7.8
  localparam int OW = 18;  // multiplier operand width
  localparam int AW = 38;  // accumulator width
  localparam int DW = 37;  // divider operand width
  localparam int QW = 16;  // divider quotient width

  localparam logic [16:0] WONE = 17'd32768;
  localparam logic [15:0] WONE16 = 16'd32768;
  localparam logic [AW-1:0] HALF = AW'(16384);

  typedef enum logic [1:0] {
    ACT_POINT = 2'd0,
    ACT_TRI   = 2'd1,
    ACT_HULL  = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_TRI_COUNT = 2'd0,
    CFG_HULL_LEN  = 2'd1,
    CFG_NEAR_ONE  = 2'd2,
    CFG_NEAR_ZERO = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MM_NUM  = 2'd0,
    MM_LEN  = 2'd1,
    MM_T    = 2'd2,
    MM_DIST = 2'd3
  } mul_mode_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TSTART, ST_TRD, ST_TPT, ST_MUL, ST_TAREA, ST_TSGN, ST_TNEG,
    ST_SORT, ST_DTOP, ST_DTOPW, ST_DPAIR, ST_DPAIRW, ST_HSTART, ST_HRD0,
    ST_HRD1, ST_HP0, ST_HP1, ST_HT, ST_HTW, ST_HEX, ST_HCMP, ST_FINAL
  } state_e;

  typedef struct packed {
    logic [1:0]           action;
    logic [4:0]           slot;
    logic signed [15:0]   coord_x;
    logic signed [15:0]   coord_y;
    logic [3:0]           vertex_a;
    logic [3:0]           vertex_b;
    logic [3:0]           vertex_c;
  } item_t;

  typedef struct packed {
    logic [1:0]           source_count;
    logic [3:0]           first_source;
    logic [3:0]           second_source;
    logic [3:0]           third_source;
    logic [15:0]          weight_first_pair;
    logic [14:0]          weight_second_pair;
    logic signed [15:0]   final_x;
    logic signed [15:0]   final_y;
    logic                 outside_hull;
  } res_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/bs2w_div.sv @@
// Radix-2 restoring divider: floor(num * 2^15 / den) for num <= den.
// One quotient bit per cycle. Depends on bs2w_pkg.
`default_nettype none
module bs2w_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bs2w_pkg::div_req_t req_i,
  output bs2w_pkg::div_rsp_t rsp_o
);
  import bs2w_pkg::*;

  localparam int NW = $clog2(QW + 1);

  logic [DW:0]   r_q;
  logic [DW-1:0] d_q;
  logic [QW-1:0] q_q;
  logic [NW-1:0] cnt_q;
  logic          done_q;
  logic          ge;
  logic [DW:0]   sub;

  assign ge  = r_q >= {1'b0, d_q};
  assign sub = r_q - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= NW'(QW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - NW'(1);
        if (cnt_q == NW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= {1'b0, req_i.num};
      d_q <= req_i.den;
    end else if (cnt_q != '0) begin
      if (ge) begin
        r_q <= {sub[DW-1:0], 1'b0};
        q_q <= {q_q[QW-2:0], 1'b1};
      end else begin
        r_q <= {r_q[DW-1:0], 1'b0};
        q_q <= {q_q[QW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;

endmodule
`default_nettype wire

@@ rtl/core/blend_space_2d_weights_top.sv @@
// 2D blend-space weight lookup: point, triangle and hull tables, a sequencer
// with one shared multiplier/accumulator and one divider. Depends on bs2w_pkg, bs2w_div.
//
// Usage: an input transaction is taken when start_i is high and busy_o low.
// Point, triangle and hull writes complete in that cycle and give no result.
// A query raises busy_o and walks the triangles in order, one at a time;
// the enclosing one adds a sort and one or two divides. If none encloses
// the point, each hull edge is measured in turn, plus a divide when its
// edge parameter needs one. The pace is set by the single multiplier
// and the bit-serial divider.
// The result appears on res_o for one cycle with res_valid_o high, in the
// cycle in which busy_o drops; the receiver cannot stall it. A query that finds no
// triangle and has fewer than two hull entries returns no result.
// Configuration writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) take effect at
// once and belong to idle periods. Reset clears the registers to 0, 0, 3, 3;
// table contents are undefined until written.
`default_nettype none
module blend_space_2d_weights_top #(
  parameter int MAX_POINTS    = 16,
  parameter int MAX_TRIANGLES = 16,
  parameter int MAX_HULL      = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  bs2w_pkg::item_t item_i,
  output logic            res_valid_o,
  output bs2w_pkg::res_t  res_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_addr_i,
  input  logic [12:0]     cfg_wdata_i
);
  import bs2w_pkg::*;

  localparam int TCW = $clog2(MAX_TRIANGLES + 1);
  localparam int HCW = $clog2(MAX_HULL + 1);

  // tables
  logic signed [CW-1:0] px_q [MAX_POINTS];
  logic signed [CW-1:0] py_q [MAX_POINTS];
  logic [11:0]          tri_q [MAX_TRIANGLES];
  logic [3:0]           hull_q [MAX_HULL];

  // config
  logic [4:0]  tri_count_q, hull_len_q;
  logic [12:0] tol1_q, tol0_q;

  state_e state_q, state_d;
  logic   res_valid_q;
  res_t   res_q, res_d;

  // datapath
  logic signed [CW-1:0] qx_q, qy_q, fx_q, fy_q, hsx_q, hsy_q;
  logic signed [OW-1:0] opa_q [3];
  logic signed [OW-1:0] opb_q [3];
  logic signed [AW-1:0] acc_q [3];
  logic signed [AW-1:0] area_q, best_q;
  logic signed [2*OW-1:0] prod_q;
  logic [1:0]  ptgt_q;
  logic        pneg_q;
  logic [2:0]  stp_q;
  mul_mode_e   mode_q, mul_mode_d;
  logic        mul_go;
  logic [3:0]  idx_q [3];
  logic [3:0]  src_q [3];
  logic [2:0]  v_q;
  logic [15:0] w01_q, t_q;
  logic [14:0] w12_q;
  logic        outside_q, have_q;
  logic [3:0]  h0_q, h1_q;
  logic [TCW-1:0] ti_q;
  logic [HCW-1:0] hi_q;

  logic in_acc, tri_more, hull_more;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign busy_o = state_q != ST_IDLE;
  assign in_acc = start_i && !busy_o;
  assign tri_more = (int'(ti_q) < int'(tri_count_q)) && (int'(ti_q) < MAX_TRIANGLES);
  assign hull_more = (int'(hi_q) < int'(hull_len_q)) && (int'(hi_q) < MAX_HULL);

  bs2w_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // table reads
  logic [3:0]           pidx;
  logic signed [CW-1:0] prd_x, prd_y;
  logic [11:0]          tri_rd;
  logic [HCW-1:0]       hidx;
  logic [3:0]           hull_rd;

  always_comb begin
    case (state_q)
      ST_HP0:  pidx = h0_q;
      ST_HP1:  pidx = h1_q;
      default: pidx = idx_q[stp_q[1:0]];
    endcase
    hidx = (state_q == ST_HRD0) ? hi_q - HCW'(1) : hi_q;
    prd_x   = '0;
    prd_y   = '0;
    tri_rd  = '0;
    hull_rd = '0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (int'(pidx) == k) begin
        prd_x = px_q[k];
        prd_y = py_q[k];
      end
    end
    for (int k = 0; k < MAX_TRIANGLES; k++) begin
      if (int'(ti_q) == k) tri_rd = tri_q[k];
    end
    for (int k = 0; k < MAX_HULL; k++) begin
      if (int'(hidx) == k) hull_rd = hull_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (item_i.action == ACT_POINT && int'(item_i.slot) == k) begin
          px_q[k] <= item_i.coord_x;
          py_q[k] <= item_i.coord_y;
        end
      end
      for (int k = 0; k < MAX_TRIANGLES; k++) begin
        if (item_i.action == ACT_TRI && int'(item_i.slot) == k) begin
          tri_q[k] <= {item_i.vertex_c, item_i.vertex_b, item_i.vertex_a};
        end
      end
      for (int k = 0; k < MAX_HULL; k++) begin
        if (item_i.action == ACT_HULL && int'(item_i.slot) == k) begin
          hull_q[k] <= item_i.vertex_a;
        end
      end
    end
  end

  // shared multiplier operand schedule
  logic [2:0]           nprod;
  logic signed [OW-1:0] ma, mb;
  logic [1:0]           mtgt;
  logic                 mneg;
  logic signed [OW-1:0] tx;

  assign tx = OW'({2'b00, t_q});

  always_comb begin
    ma = '0;
    mb = '0;
    mtgt = 2'd0;
    mneg = 1'b0;
    case (mode_q)
      MM_NUM:  nprod = 3'd6;
      MM_LEN:  nprod = 3'd4;
      default: nprod = 3'd2;
    endcase
    case (mode_q)
      MM_NUM: begin
        case (stp_q)
          3'd0: begin ma = opa_q[1]; mb = opb_q[2]; mtgt = 2'd0; end
          3'd1: begin ma = opb_q[1]; mb = opa_q[2]; mtgt = 2'd0; mneg = 1'b1; end
          3'd2: begin ma = opa_q[2]; mb = opb_q[0]; mtgt = 2'd1; end
          3'd3: begin ma = opb_q[2]; mb = opa_q[0]; mtgt = 2'd1; mneg = 1'b1; end
          3'd4: begin ma = opa_q[0]; mb = opb_q[1]; mtgt = 2'd2; end
          default: begin ma = opb_q[0]; mb = opa_q[1]; mtgt = 2'd2; mneg = 1'b1; end
        endcase
      end
      MM_LEN: begin
        case (stp_q)
          3'd0: begin ma = opa_q[1]; mb = opa_q[1]; end
          3'd1: begin ma = opb_q[1]; mb = opb_q[1]; end
          3'd2: begin ma = opa_q[0]; mb = opa_q[1]; mtgt = 2'd1; end
          default: begin ma = opb_q[0]; mb = opb_q[1]; mtgt = 2'd1; end
        endcase
      end
      MM_T: begin
        if (stp_q == 3'd0) begin
          ma = tx; mb = opa_q[1];
        end else begin
          ma = tx; mb = opb_q[1]; mtgt = 2'd1;
        end
      end
      default: begin
        if (stp_q == 3'd0) begin
          ma = opa_q[2]; mb = opa_q[2];
        end else begin
          ma = opb_q[2]; mb = opb_q[2];
        end
      end
    endcase
  end

  // sort, near-one, hull helpers
  logic [1:0] slo, shi;
  logic       sswap, near_one, any_neg, hpos;
  logic signed [AW-1:0] rndx, rndy;
  logic signed [CW-1:0] cx_c, cy_c;

  assign slo = (stp_q == 3'd1) ? 2'd1 : 2'd0;
  assign shi = slo + 2'd1;
  assign sswap = acc_q[shi] < acc_q[slo];
  assign near_one = (WONE - {1'b0, div_rsp.quot}) <= {4'b0, tol1_q};
  assign any_neg = acc_q[0][AW-1] | acc_q[1][AW-1] | acc_q[2][AW-1];
  assign hpos = (acc_q[0] > 0) && (acc_q[1] > 0);
  assign rndx = acc_q[0] + HALF;
  assign rndy = acc_q[1] + HALF;
  assign cx_c = hsx_q + rndx[30:15];
  assign cy_c = hsy_q + rndy[30:15];

  // sequencer
  always_comb begin
    state_d = state_q;
    mul_go = 1'b0;
    mul_mode_d = MM_NUM;
    div_req.start = 1'b0;
    case (state_q)
      ST_DPAIR: begin
        div_req.num = acc_q[1][DW-1:0];
        div_req.den = area_q[DW-1:0];
      end
      ST_HT: begin
        div_req.num = acc_q[1][DW-1:0];
        div_req.den = acc_q[0][DW-1:0];
      end
      default: begin
        div_req.num = acc_q[2][DW-1:0];
        div_req.den = area_q[DW-1:0];
      end
    endcase
    case (state_q)
      ST_IDLE: if (in_acc && item_i.action == ACT_QUERY) state_d = ST_TSTART;
      ST_TSTART: state_d = tri_more ? ST_TRD : ST_HSTART;
      ST_TRD: state_d = ST_TPT;
      ST_TPT: begin
        if (stp_q == 3'd2) begin
          mul_go = 1'b1;
          mul_mode_d = MM_NUM;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (stp_q == nprod) begin
          case (mode_q)
            MM_NUM:  state_d = ST_TAREA;
            MM_LEN:  state_d = ST_HT;
            MM_T:    state_d = ST_HEX;
            default: state_d = ST_HCMP;
          endcase
        end
      end
      ST_TAREA: state_d = ST_TSGN;
      ST_TSGN: state_d = (area_q == '0) ? ST_TSTART : ST_TNEG;
      ST_TNEG: state_d = any_neg ? ST_TSTART : ST_SORT;
      ST_SORT: if (stp_q == 3'd2) state_d = ST_DTOP;
      ST_DTOP: begin
        div_req.start = 1'b1;
        state_d = ST_DTOPW;
      end
      ST_DTOPW: if (div_rsp.done) state_d = near_one ? ST_FINAL : ST_DPAIR;
      ST_DPAIR: begin
        if (area_q != '0) begin
          div_req.start = 1'b1;
          state_d = ST_DPAIRW;
        end else begin
          state_d = ST_FINAL;
        end
      end
      ST_DPAIRW: if (div_rsp.done) state_d = ST_FINAL;
      ST_HSTART: begin
        if (hull_more) state_d = ST_HRD0;
        else state_d = have_q ? ST_FINAL : ST_IDLE;
      end
      ST_HRD0: state_d = ST_HRD1;
      ST_HRD1: state_d = ST_HP0;
      ST_HP0: state_d = ST_HP1;
      ST_HP1: begin
        mul_go = 1'b1;
        mul_mode_d = MM_LEN;
        state_d = ST_MUL;
      end
      ST_HT: begin
        if (hpos && !(acc_q[1] >= acc_q[0])) begin
          div_req.start = 1'b1;
          state_d = ST_HTW;
        end else begin
          mul_go = 1'b1;
          mul_mode_d = MM_T;
          state_d = ST_MUL;
        end
      end
      ST_HTW: begin
        if (div_rsp.done) begin
          mul_go = 1'b1;
          mul_mode_d = MM_T;
          state_d = ST_MUL;
        end
      end
      ST_HEX: begin
        mul_go = 1'b1;
        mul_mode_d = MM_DIST;
        state_d = ST_MUL;
      end
      ST_HCMP: state_d = ST_HSTART;
      ST_FINAL: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          qx_q <= item_i.coord_x;
          qy_q <= item_i.coord_y;
          fx_q <= item_i.coord_x;
          fy_q <= item_i.coord_y;
          outside_q <= 1'b0;
          have_q <= 1'b0;
          ti_q <= '0;
        end
      end
      ST_TSTART: if (!tri_more) hi_q <= HCW'(1);
      ST_TRD: begin
        idx_q[0] <= tri_rd[3:0];
        idx_q[1] <= tri_rd[7:4];
        idx_q[2] <= tri_rd[11:8];
        stp_q <= 3'd0;
      end
      ST_TPT: begin
        opa_q[stp_q[1:0]] <= OW'(prd_x) - OW'(qx_q);
        opb_q[stp_q[1:0]] <= OW'(prd_y) - OW'(qy_q);
        if (!mul_go) stp_q <= stp_q + 3'd1;
      end
      ST_MUL: begin
        if (stp_q < nprod) begin
          prod_q <= ma * mb;
          ptgt_q <= mtgt;
          pneg_q <= mneg;
        end
        if (stp_q != 3'd0) begin
          if (pneg_q) acc_q[ptgt_q] <= acc_q[ptgt_q] - AW'(prod_q);
          else acc_q[ptgt_q] <= acc_q[ptgt_q] + AW'(prod_q);
        end
        stp_q <= stp_q + 3'd1;
      end
      ST_TAREA: area_q <= acc_q[0] + acc_q[1] + acc_q[2];
      ST_TSGN: begin
        if (area_q == '0) begin
          ti_q <= ti_q + TCW'(1);
        end else if (area_q < 0) begin
          area_q <= -area_q;
          for (int k = 0; k < 3; k++) acc_q[k] <= -acc_q[k];
        end
      end
      ST_TNEG: begin
        if (any_neg) ti_q <= ti_q + TCW'(1);
        else stp_q <= 3'd0;
      end
      ST_SORT: begin
        if (sswap) begin
          acc_q[slo] <= acc_q[shi];
          acc_q[shi] <= acc_q[slo];
          idx_q[slo] <= idx_q[shi];
          idx_q[shi] <= idx_q[slo];
        end
        stp_q <= stp_q + 3'd1;
      end
      ST_DTOPW: begin
        if (div_rsp.done) begin
          if (near_one) begin
            src_q[0] <= idx_q[2];
            v_q <= 3'b001;
            w01_q <= '0;
            w12_q <= '0;
          end else begin
            for (int k = 0; k < 3; k++) src_q[k] <= idx_q[k];
            v_q <= 3'b111;
            w12_q <= div_rsp.quot[14:0];
            area_q <= acc_q[0] + acc_q[1];
          end
        end
      end
      ST_DPAIR: if (area_q == '0) w01_q <= '0;
      ST_DPAIRW: if (div_rsp.done) w01_q <= div_rsp.quot;
      ST_HSTART: begin
        if (!hull_more && have_q) begin
          v_q <= 3'b011;
          w12_q <= '0;
          outside_q <= 1'b1;
        end
      end
      ST_HRD0: h0_q <= hull_rd;
      ST_HRD1: h1_q <= hull_rd;
      ST_HP0: begin
        hsx_q <= prd_x;
        hsy_q <= prd_y;
        opa_q[0] <= OW'(qx_q) - OW'(prd_x);
        opb_q[0] <= OW'(qy_q) - OW'(prd_y);
      end
      ST_HP1: begin
        opa_q[1] <= OW'(prd_x) - OW'(hsx_q);
        opb_q[1] <= OW'(prd_y) - OW'(hsy_q);
      end
      ST_HT: begin
        if (!hpos) t_q <= '0;
        else if (acc_q[1] >= acc_q[0]) t_q <= WONE16;
      end
      ST_HTW: if (div_rsp.done) t_q <= div_rsp.quot;
      ST_HEX: begin
        hsx_q <= cx_c;
        hsy_q <= cy_c;
        opa_q[2] <= OW'(qx_q) - OW'(cx_c);
        opb_q[2] <= OW'(qy_q) - OW'(cy_c);
      end
      ST_HCMP: begin
        if (!have_q || acc_q[0] < best_q) begin
          have_q <= 1'b1;
          best_q <= acc_q[0];
          src_q[0] <= h0_q;
          src_q[1] <= h1_q;
          fx_q <= hsx_q;
          fy_q <= hsy_q;
          w01_q <= t_q;
        end
        hi_q <= hi_q + HCW'(1);
      end
      default: ;
    endcase
    if (mul_go) begin
      for (int k = 0; k < 3; k++) acc_q[k] <= '0;
      stp_q <= 3'd0;
      mode_q <= mul_mode_d;
    end
  end

  // final near-zero / near-one simplification
  always_comb begin
    logic [3:0]  s0, s1, s2;
    logic [2:0]  v;
    logic [15:0] w01;
    logic [14:0] w12;
    logic        low;
    s0 = src_q[0];
    s1 = src_q[1];
    s2 = src_q[2];
    v = v_q;
    w01 = w01_q;
    w12 = w12_q;
    low = w01_q <= {3'b000, tol0_q};
    if ((WONE - {1'b0, w01_q}) <= {4'b0, tol0_q} || (low && v_q[2])) begin
      s0 = s1;
      s1 = s2;
      v = {1'b0, v_q[2], v_q[1]};
      w01 = {1'b0, w12_q};
      w12 = '0;
    end else if (low) begin
      v[1] = 1'b0;
    end
    res_d.source_count = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    res_d.first_source = v[0] ? s0 : 4'd0;
    res_d.second_source = v[1] ? s1 : 4'd0;
    res_d.third_source = v[2] ? s2 : 4'd0;
    res_d.weight_first_pair = w01;
    res_d.weight_second_pair = w12;
    res_d.final_x = fx_q;
    res_d.final_y = fy_q;
    res_d.outside_hull = outside_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINAL) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_valid_q <= 1'b0;
      tri_count_q <= '0;
      hull_len_q <= '0;
      tol1_q <= 13'd3;
      tol0_q <= 13'd3;
    end else begin
      state_q <= state_d;
      res_valid_q <= state_q == ST_FINAL;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_TRI_COUNT: tri_count_q <= cfg_wdata_i[4:0];
          CFG_HULL_LEN:  hull_len_q <= cfg_wdata_i[4:0];
          CFG_NEAR_ONE:  tol1_q <= cfg_wdata_i;
          CFG_NEAR_ZERO: tol0_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

endmodule
`default_nettype wire

@@ tb/blend_space_2d_weights_top_tb.sv @@
// Self-checking testbench for blend_space_2d_weights_top: loads point, triangle
// and hull tables, sends queries and checks each result against a built-in predictor.
// Depends on bs2w_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module blend_space_2d_weights_top_tb;
  import bs2w_pkg::*;

  localparam int NPTS = 16;
  localparam int NTRI = 16;
  localparam int NHULL = 17;
  localparam longint UNIT = 32768;
  localparam int NO_SRC = 255;
  localparam longint CYCLE_LIMIT = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  item_t       item_i = '0;
  logic        res_valid_o;
  res_t        res_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [12:0] cfg_wdata_i = '0;

  blend_space_2d_weights_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .item_i(item_i), .res_valid_o(res_valid_o), .res_o(res_o),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow tables and registers
  longint      pt_x[NPTS];
  longint      pt_y[NPTS];
  logic [11:0] tri_v[NTRI];
  logic [3:0]  hull_v[NHULL];
  int          tri_count_r = 0;
  int          hull_len_r = 0;
  longint      near_one_r = 3;
  longint      near_zero_r = 3;

  res_t   weights_q[$];
  int     gap_pct = 0;
  int     errors = 0;
  int     n_queries = 0;
  int     n_results = 0;
  int     n_outside = 0;
  int     n_dropped = 0;
  longint cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("blend_space_2d_weights_top verification failed");
      $finish;
    end
  end

  function automatic longint cross3(longint ax, longint ay, longint bx, longint by,
                                    longint qx, longint qy);
    return (ax - qx) * (by - qy) - (ay - qy) * (bx - qx);
  endfunction

  function automatic longint fdiv(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic bit blend_weights(input item_t it, output res_t r);
    longint qx, qy, num[3], area, tw, top, pair, w01, w12, fx, fy;
    longint best, sx, sy, dx, dy, len2, dot, t, cx, cy, ex, ey, sqdist, d1;
    int     idx[3], src[3], ti, ntri, nhull, bestk, cnt;
    bit     found, outside, have;
    qx = it.coord_x; qy = it.coord_y;
    fx = qx; fy = qy; w01 = 0; w12 = 0;
    src = '{NO_SRC, NO_SRC, NO_SRC};
    found = 0; outside = 0; have = 0; best = 0; bestk = 0;
    ntri = tri_count_r > NTRI ? NTRI : tri_count_r;
    for (int i = 0; i < ntri && !found; i++) begin
      idx[0] = tri_v[i][3:0]; idx[1] = tri_v[i][7:4]; idx[2] = tri_v[i][11:8];
      num[0] = cross3(pt_x[idx[1]], pt_y[idx[1]], pt_x[idx[2]], pt_y[idx[2]], qx, qy);
      num[1] = cross3(pt_x[idx[2]], pt_y[idx[2]], pt_x[idx[0]], pt_y[idx[0]], qx, qy);
      num[2] = cross3(pt_x[idx[0]], pt_y[idx[0]], pt_x[idx[1]], pt_y[idx[1]], qx, qy);
      area = num[0] + num[1] + num[2];
      if (area == 0) continue;
      if (area < 0) begin
        area = -area;
        for (int k = 0; k < 3; k++) num[k] = -num[k];
      end
      if (num[0] < 0 || num[1] < 0 || num[2] < 0) continue;
      for (int m = 1; m < 3; m++)
        for (int n = m; n > 0 && num[n] < num[n-1]; n--) begin
          tw = num[n]; num[n] = num[n-1]; num[n-1] = tw;
          ti = idx[n]; idx[n] = idx[n-1]; idx[n-1] = ti;
        end
      top = (num[2] * UNIT) / area;
      if (UNIT - top <= near_one_r) begin
        src[0] = idx[2];
      end else begin
        pair = num[0] + num[1];
        src = '{idx[0], idx[1], idx[2]};
        w01 = pair > 0 ? (num[1] * UNIT) / pair : 0;
        w12 = top;
      end
      found = 1;
    end
    if (!found) begin
      nhull = hull_len_r > NHULL ? NHULL : hull_len_r;
      for (int i = 1; i < nhull; i++) begin
        sx = pt_x[hull_v[i-1]]; sy = pt_y[hull_v[i-1]];
        dx = pt_x[hull_v[i]] - sx; dy = pt_y[hull_v[i]] - sy;
        len2 = dx * dx + dy * dy;
        dot = (qx - sx) * dx + (qy - sy) * dy;
        t = 0;
        if (len2 > 0 && dot > 0) t = dot >= len2 ? UNIT : (dot * UNIT) / len2;
        cx = sx + fdiv(t * dx + 16384, UNIT);
        cy = sy + fdiv(t * dy + 16384, UNIT);
        ex = qx - cx; ey = qy - cy;
        sqdist = ex * ex + ey * ey;
        if (!have || sqdist < best) begin
          have = 1; best = sqdist; bestk = i;
          fx = cx; fy = cy; w01 = t;
        end
      end
      if (!have) return 0;
      src = '{hull_v[bestk-1], hull_v[bestk], NO_SRC};
      w12 = 0;
      outside = 1;
    end
    d1 = w01 - UNIT;
    if (d1 < 0) d1 = -d1;
    if (d1 <= near_zero_r || (w01 <= near_zero_r && src[2] != NO_SRC)) begin
      src = '{src[1], src[2], NO_SRC};
      w01 = w12; w12 = 0;
    end else if (w01 <= near_zero_r) begin
      src[1] = NO_SRC;
    end
    cnt = 0;
    for (int k = 0; k < 3; k++) if (src[k] != NO_SRC) cnt++;
    r.source_count       = cnt[1:0];
    r.first_source       = src[0] == NO_SRC ? 4'd0 : src[0][3:0];
    r.second_source      = src[1] == NO_SRC ? 4'd0 : src[1][3:0];
    r.third_source       = src[2] == NO_SRC ? 4'd0 : src[2][3:0];
    r.weight_first_pair  = w01[15:0];
    r.weight_second_pair = w12[14:0];
    r.final_x            = fx[15:0];
    r.final_y            = fy[15:0];
    r.outside_hull       = outside;
    return 1;
  endfunction

  // one transaction; start_i stays high afterwards so writes can go back to back
  task automatic send(input item_t it);
    res_t r;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (action_e'(it.action))
      ACT_POINT: if (it.slot < NPTS) begin
        pt_x[it.slot] = it.coord_x; pt_y[it.slot] = it.coord_y;
      end
      ACT_TRI: if (it.slot < NTRI) tri_v[it.slot] = {it.vertex_c, it.vertex_b, it.vertex_a};
      ACT_HULL: if (it.slot < NHULL) hull_v[it.slot] = it.vertex_a;
      ACT_QUERY: begin
        n_queries++;
        if (blend_weights(it, r)) weights_q.push_back(r);
        else n_dropped++;
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (busy_o || weights_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val[12:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TRI_COUNT: tri_count_r = val & 31;
      CFG_HULL_LEN:  hull_len_r = val & 31;
      CFG_NEAR_ONE:  near_one_r = val & 8191;
      CFG_NEAR_ZERO: near_zero_r = val & 8191;
      default: ;
    endcase
  endtask

  function automatic item_t mk(action_e a, int slot, int x, int y, int va, int vb, int vc);
    item_t it;
    it.action = a; it.slot = slot[4:0];
    it.coord_x = x[15:0]; it.coord_y = y[15:0];
    it.vertex_a = va[3:0]; it.vertex_b = vb[3:0]; it.vertex_c = vc[3:0];
    return it;
  endfunction

  function automatic int rcoord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // fills every entry, so nothing unwritten is ever read
  task automatic load_tables(input int span);
    for (int i = 0; i < NPTS; i++)
      send(mk(ACT_POINT, i, rcoord(span), rcoord(span), $urandom, $urandom, $urandom));
    for (int i = 0; i < NTRI; i++)
      send(mk(ACT_TRI, i, $urandom, $urandom, $urandom, $urandom, $urandom));
    for (int i = 0; i < NHULL; i++)
      send(mk(ACT_HULL, i, $urandom, $urandom, $urandom, $urandom, $urandom));
  endtask

  function automatic item_t rand_query(input int span);
    int t, a, b, c, w0, w1, w2, s, x, y;
    t = $urandom_range(NTRI - 1);
    a = tri_v[t][3:0]; b = tri_v[t][7:4]; c = tri_v[t][11:8];
    case ($urandom_range(5))
      0, 1, 2: begin
        w0 = $urandom_range(255); w1 = $urandom_range(255); w2 = $urandom_range(255);
        s = w0 + w1 + w2 + 1;
        x = int'((w0 * pt_x[a] + w1 * pt_x[b] + w2 * pt_x[c]) / s)
            + int'($urandom_range(2)) - 1;
        y = int'((w0 * pt_y[a] + w1 * pt_y[b] + w2 * pt_y[c]) / s)
            + int'($urandom_range(2)) - 1;
      end
      3: begin
        x = int'(pt_x[a]) + int'($urandom_range(2)) - 1;
        y = int'(pt_y[a]) + int'($urandom_range(2)) - 1;
      end
      4: begin
        x = int'((pt_x[a] + pt_x[b]) / 2); y = int'((pt_y[a] + pt_y[b]) / 2);
      end
      default: begin
        x = $urandom; y = $urandom;
      end
    endcase
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return mk(ACT_QUERY, $urandom, x, y, $urandom, $urandom, $urandom);
  endfunction

  // result checker: the receiver never stalls, so every strobe is a transaction
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      if (weights_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = weights_q.pop_front();
        n_results++;
        if (e.outside_hull) n_outside++;
        if (res_o.source_count !== e.source_count) begin
          $error("source_count exp %0d got %0d", e.source_count, res_o.source_count); errors++;
        end
        if (res_o.first_source !== e.first_source) begin
          $error("first_source exp %0d got %0d", e.first_source, res_o.first_source); errors++;
        end
        if (res_o.second_source !== e.second_source) begin
          $error("second_source exp %0d got %0d", e.second_source, res_o.second_source);
          errors++;
        end
        if (res_o.third_source !== e.third_source) begin
          $error("third_source exp %0d got %0d", e.third_source, res_o.third_source); errors++;
        end
        if (res_o.weight_first_pair !== e.weight_first_pair) begin
          $error("weight_first_pair exp %0d got %0d", e.weight_first_pair,
                 res_o.weight_first_pair);
          errors++;
        end
        if (res_o.weight_second_pair !== e.weight_second_pair) begin
          $error("weight_second_pair exp %0d got %0d", e.weight_second_pair,
                 res_o.weight_second_pair);
          errors++;
        end
        if (res_o.final_x !== e.final_x) begin
          $error("final_x exp %0d got %0d", e.final_x, res_o.final_x); errors++;
        end
        if (res_o.final_y !== e.final_y) begin
          $error("final_y exp %0d got %0d", e.final_y, res_o.final_y); errors++;
        end
        if (res_o.outside_hull !== e.outside_hull) begin
          $error("outside_hull exp %0d got %0d", e.outside_hull, res_o.outside_hull); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    load_tables(2000);
    // empty triangle list, hull too short: no result
    send(mk(ACT_QUERY, 0, 100, 100, 0, 0, 0));
    write_reg(CFG_HULL_LEN, 1);
    send(mk(ACT_QUERY, 0, -100, 50, 0, 0, 0));
    // corners of the coordinate range
    send(mk(ACT_POINT, 0, -32768, -32768, 0, 0, 0));
    send(mk(ACT_POINT, 1, 32767, -32768, 0, 0, 0));
    send(mk(ACT_POINT, 2, -32768, 32767, 0, 0, 0));
    send(mk(ACT_POINT, 3, 32767, 32767, 0, 0, 0));
    send(mk(ACT_POINT, 31, 5, 5, 15, 15, 15));
    send(mk(ACT_TRI, 0, 0, 0, 0, 0, 1));     // zero area
    send(mk(ACT_TRI, 1, 0, 0, 0, 1, 2));
    send(mk(ACT_TRI, 2, 0, 0, 1, 3, 2));     // same winding as slot 1
    send(mk(ACT_TRI, 16, 0, 0, 15, 15, 15));
    send(mk(ACT_HULL, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_HULL, 1, 0, 0, 1, 0, 0));
    send(mk(ACT_HULL, 2, 0, 0, 3, 0, 0));
    send(mk(ACT_HULL, 3, 0, 0, 2, 0, 0));
    send(mk(ACT_HULL, 4, 0, 0, 0, 0, 0));
    send(mk(ACT_HULL, 17, 0, 0, 15, 0, 0));
    write_reg(CFG_TRI_COUNT, 3);
    write_reg(CFG_HULL_LEN, 5);
    send(mk(ACT_QUERY, 0, 32767, 32767, 0, 0, 0));   // on a vertex
    send(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_QUERY, 0, 0, -32768, 0, 0, 0));      // on an edge
    send(mk(ACT_QUERY, 0, 20000, -12345, 0, 0, 0));
    // only the degenerate triangle: every query goes to the hull
    write_reg(CFG_TRI_COUNT, 1);
    send(mk(ACT_QUERY, 0, 1000, -7000, 0, 0, 0));
    send(mk(ACT_QUERY, 0, -32768, 32767, 0, 0, 0));
    write_reg(CFG_NEAR_ONE, 0);
    write_reg(CFG_NEAR_ZERO, 0);
    write_reg(CFG_TRI_COUNT, 3);
    send(mk(ACT_QUERY, 0, 32766, 32766, 0, 0, 0));
    send(mk(ACT_QUERY, 0, -5, -32767, 0, 0, 0));
  endtask

  task automatic test_random(input int span, input int tcount, input int hlen,
                             input int tol1, input int tol0, input int n);
    int pick;
    wait_idle();
    load_tables(span);
    write_reg(CFG_TRI_COUNT, tcount);
    write_reg(CFG_HULL_LEN, hlen);
    write_reg(CFG_NEAR_ONE, tol1);
    write_reg(CFG_NEAR_ZERO, tol0);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      if (pick < 6) send(rand_query(span));
      else if (pick == 6)
        send(mk(ACT_POINT, $urandom_range(31), rcoord(span), rcoord(span),
                $urandom, $urandom, $urandom));
      else if (pick == 7)
        send(mk(ACT_TRI, $urandom_range(31), $urandom, $urandom,
                $urandom, $urandom, $urandom));
      else
        send(mk(ACT_HULL, $urandom_range(31), $urandom, $urandom,
                $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    gap_pct = 0;
    test_random(1500, 16, 17, 3, 3, 45);
    gap_pct = 67;
    test_random(32767, 31, 31, 8191, 4096, 45);
    gap_pct = 0;
    test_random(400, 8, 9, 4096, 0, 45);
    gap_pct = 30;
    test_random(6000, 4, 6, 100, 8191, 45);
    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d queries: %0d results (%0d off the hull), %0d without a result.",
             n_queries, n_results, n_outside, n_dropped);
    if (errors == 0 && weights_q.size() == 0) begin
      $display("blend_space_2d_weights_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, weights_q.size());
      $display("blend_space_2d_weights_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/bs2w_pkg.sv
rtl/core/bs2w_div.sv
rtl/core/blend_space_2d_weights_top.sv
tb/blend_space_2d_weights_top_tb.sv
